>>> rtl/bptc_pkg.sv
// Shared types and constants for the barometric pressure and temperature compensation block.
// No dependencies; imported by the pipeline top level and its port checker.
`default_nettype none

package bptc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIV_ZERO  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	// Temperature divider: 20-bit divisor magnitude, 27-bit quotient
	localparam int TQ_DW = 20;
	localparam int TQ_QW = 27;
	// Pressure divider: 17-bit divisor, 32-bit quotient
	localparam int PQ_DW = 17;
	localparam int PQ_QW = 32;

	// Compensation constants
	localparam logic signed [27:0] B6_OFFSET = 28'sd4000;
	localparam logic [31:0]        B4_BIAS   = 32'd32768;
	localparam logic [11:0]        P_SQ_GAIN = 12'd3038;
	localparam logic signed [14:0] P_LIN_GAIN = -15'sd7357;
	localparam logic signed [48:0] P_OFFSET  = 49'sd3791;
	localparam logic signed [15:0] TEMP_MAX  = 16'sh7FFF;
	localparam logic signed [15:0] TEMP_MIN  = -16'sh8000;
	localparam logic [21:0]        PRES_MAX  = 22'h3FFFFF;

	// Pressure scale 50000 >> oss
	function automatic logic [15:0] oss_scale(input logic [1:0] oss);
		logic [15:0] s;
		case (oss)
			2'd0:    s = 16'd50000;
			2'd1:    s = 16'd25000;
			2'd2:    s = 16'd12500;
			default: s = 16'd6250;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/baro_pressure_temp_compensation.sv
// Usage:
//   Input channel in_valid/in_ready carries raw_temperature and uncomp_pressure; a transfer
//   takes place at a clock edge where both are high. Output channel out_valid/out_ready
//   carries temperature_tenths, pressure_sixteenths and status, one result per item,
//   in order.
//   Coefficients and the oversampling mode are written through cfg_we/cfg_index/cfg_data,
//   one register per cycle, while no item is in flight.
//   Throughput: one item per cycle when no stall holds the pipeline. An item passes from
//   input transfer to out_valid through the two one-bit-per-stage dividers (27 stages for
//   the temperature quotient, 32 for the pressure quotient) plus ten arithmetic stages.
//   Stall: the whole pipeline advances only while the output register is empty or being
//   taken; when the receiver holds out_ready low with a result waiting, in_ready drops and
//   every stage holds.
//   Reset (arst_n low): all valid bits clear, coefficients return to zero and the
//   oversampling mode to 3. No clearing pass is needed.
//   Status: a zero divisor gives ST_DIV_ZERO with zero values; a clamped value gives
//   ST_SATURATED.
// Depends on bptc_pkg.
`default_nettype none

module baro_pressure_temp_compensation
	import bptc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        raw_temperature,
	input  wire logic [18:0]        uncomp_pressure,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      temperature_tenths,
	output logic [21:0]             pressure_sixteenths,
	output logic [1:0]              status
);

	typedef struct packed {
		logic [TQ_DW-1:0]  rem;
		logic [TQ_QW-1:0]  qn;
		logic [TQ_DW-1:0]  dv;
		logic signed [19:0] x1;
		logic              neg;
		logic              err;
		logic [18:0]       up;
	} tq_t;

	typedef struct packed {
		logic [PQ_DW-1:0]  rem;
		logic [PQ_QW-1:0]  qn;
		logic [PQ_DW-1:0]  dv;
		logic              sel;
		logic              err;
		logic signed [15:0] t16;
		logic              tsat;
	} pq_t;

	// One restoring division step for the temperature quotient
	function automatic tq_t tq_step(input tq_t a);
		tq_t r;
		logic [TQ_DW:0] t;
		r = a;
		t = {a.rem, a.qn[TQ_QW-1]};
		if (t >= {1'b0, a.dv}) begin
			r.rem = TQ_DW'(t - {1'b0, a.dv});
			r.qn  = {a.qn[TQ_QW-2:0], 1'b1};
		end else begin
			r.rem = t[TQ_DW-1:0];
			r.qn  = {a.qn[TQ_QW-2:0], 1'b0};
		end
		return r;
	endfunction

	// One restoring division step for the pressure quotient
	function automatic pq_t pq_step(input pq_t a);
		pq_t r;
		logic [PQ_DW:0] t;
		r = a;
		t = {a.rem, a.qn[PQ_QW-1]};
		if (t >= {1'b0, a.dv}) begin
			r.rem = PQ_DW'(t - {1'b0, a.dv});
			r.qn  = {a.qn[PQ_QW-2:0], 1'b1};
		end else begin
			r.rem = t[PQ_DW-1:0];
			r.qn  = {a.qn[PQ_QW-2:0], 1'b0};
		end
		return r;
	endfunction

	// Configuration registers
	logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q   <= '0;
			mc_md_q   <= '0;
			oss_q     <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1_AC2: ac1_ac2_q <= cfg_data;
				REG_AC3_AC4: ac3_ac4_q <= cfg_data;
				REG_AC5_AC6: ac5_ac6_q <= cfg_data;
				REG_B1_B2:   b1_b2_q   <= cfg_data;
				REG_MC_MD:   mc_md_q   <= cfg_data;
				REG_OSS:     oss_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Coefficient fields
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	assign ac1 = $signed(ac1_ac2_q[31:16]);
	assign ac2 = $signed(ac1_ac2_q[15:0]);
	assign ac3 = $signed(ac3_ac4_q[31:16]);
	assign ac4 = ac3_ac4_q[15:0];
	assign ac5 = ac5_ac6_q[31:16];
	assign ac6 = ac5_ac6_q[15:0];
	assign b1  = $signed(b1_b2_q[31:16]);
	assign b2  = $signed(b1_b2_q[15:0]);
	assign mc  = $signed(mc_md_q[31:16]);
	assign md  = $signed(mc_md_q[15:0]);

	// Global advance: move every stage when the output register can take a result
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign out_valid = out_valid_q;

	// Pipeline registers
	logic                v_s1, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [34:0]  prod1_s1;
	logic [18:0]         up_s1;
	tq_t                 tq_s   [TQ_QW];
	logic                tq_v_s [TQ_QW];
	pq_t                 pq_s   [PQ_QW];
	logic                pq_v_s [PQ_QW];

	logic signed [28:0]  b6_s3;
	logic [18:0]         up_s3, up_s4, up_s5, up_s6, up_s7;
	logic                err_s3, err_s4, err_s5, err_s6, err_s7, err_s8, err_s9, err_s10;
	logic signed [15:0]  t16_s3, t16_s4, t16_s5, t16_s6, t16_s7, t16_s8, t16_s9, t16_s10;
	logic                tsat_s3, tsat_s4, tsat_s5, tsat_s6, tsat_s7, tsat_s8, tsat_s9;
	logic                tsat_s10;
	logic signed [57:0]  sqp_s4;
	logic signed [44:0]  ac2b6_s4, ac3b6_s4, ac2b6_s5, ac3b6_s5;
	logic signed [61:0]  b2sq_s5, b1sq_s5;
	logic signed [51:0]  x3a_s6;
	logic signed [44:0]  x3b_s6;
	logic [31:0]         b3_s7, b4p_s7, b7_s8;
	logic [16:0]         b4_s8;
	logic [32:0]         p_s9, p_s10;
	logic [49:0]         sqr_s9;
	logic signed [47:0]  x2m_s9;
	logic [61:0]         m3_s10;
	logic signed [31:0]  x2_s10;

	// Stage 1: (UT - AC6) * AC5
	logic signed [17:0] t_diff;
	assign t_diff = $signed({2'b00, raw_temperature}) - $signed({2'b00, ac6});

	// Temperature divider load: X1, denominator, operand magnitudes
	logic signed [19:0] x1_t, den;
	logic [TQ_DW-1:0]   dmag;
	logic [15:0]        mcmag;
	tq_t                tq_ld;

	always_comb begin
		x1_t  = 20'(prod1_s1 >>> 15);
		den   = x1_t + {{4{md[15]}}, md};
		dmag  = den[19] ? TQ_DW'(-den) : TQ_DW'(den);
		mcmag = mc[15] ? 16'(-mc) : mc;
		tq_ld     = '0;
		tq_ld.qn  = {mcmag, 11'b0};
		tq_ld.dv  = dmag;
		tq_ld.x1  = x1_t;
		tq_ld.neg = mc[15] ^ den[19];
		tq_ld.err = (den == '0);
		tq_ld.up  = up_s1;
	end

	// Stage 3: B5, B6 and saturated temperature
	logic signed [27:0] x2_t, b5;
	logic signed [23:0] tt;
	logic signed [15:0] t16_c;
	logic               tsat_c;
	tq_t                tq_last;

	always_comb begin
		tq_last = tq_s[TQ_QW-1];
		x2_t = tq_last.neg ? -$signed({1'b0, tq_last.qn}) : $signed({1'b0, tq_last.qn});
		b5   = 28'(tq_last.x1) + x2_t;
		tt   = 24'((b5 + 28'sd8) >>> 4);
		tsat_c = 1'b0;
		if (tt > 24'(TEMP_MAX)) begin
			t16_c  = TEMP_MAX;
			tsat_c = 1'b1;
		end else if (tt < 24'(TEMP_MIN)) begin
			t16_c  = TEMP_MIN;
			tsat_c = 1'b1;
		end else begin
			t16_c = tt[15:0];
		end
	end

	// Stage 4 and 5 products
	logic signed [57:0] sqp_c;
	logic signed [44:0] ac2b6_c, ac3b6_c;
	logic signed [45:0] sq;
	logic signed [61:0] b2sq_c, b1sq_c;

	assign sqp_c   = b6_s3 * b6_s3;
	assign ac2b6_c = ac2 * b6_s3;
	assign ac3b6_c = ac3 * b6_s3;
	assign sq      = 46'(sqp_s4 >>> 12);
	assign b2sq_c  = b2 * sq;
	assign b1sq_c  = b1 * sq;

	// Stage 6: X3 sums for B3 and B4
	logic signed [51:0] x3a_c;
	logic signed [46:0] x3b_sum;

	assign x3a_c   = 52'(b2sq_s5 >>> 11) + 52'(ac2b6_s5 >>> 11);
	assign x3b_sum = 47'(ac3b6_s5 >>> 13) + 47'(b1sq_s5 >>> 16) + 47'sd2;

	// Stage 7: B3 low word and B4 product
	logic signed [52:0] b3_v;
	logic signed [55:0] b3_sh, b3_r;
	logic [31:0]        b4_u;
	logic [47:0]        b4_full;

	assign b3_v    = (53'(ac1) <<< 2) + 53'(x3a_s6);
	assign b3_sh   = 56'(b3_v) <<< oss_q;
	assign b3_r    = b3_sh + 56'sd2;
	assign b4_u    = 32'(x3b_s6) + B4_BIAS;
	assign b4_full = ac4 * b4_u;

	// Stage 8: B7
	logic [31:0] b7_diff;
	logic [47:0] b7_full;

	assign b7_diff = {13'b0, up_s7} - b3_s7;
	assign b7_full = b7_diff * oss_scale(oss_q);

	// Pressure divider load: pick doubled dividend or doubled quotient
	pq_t pq_ld;

	always_comb begin
		pq_ld      = '0;
		pq_ld.sel  = b7_s8[31];
		pq_ld.qn   = b7_s8[31] ? b7_s8 : {b7_s8[30:0], 1'b0};
		pq_ld.dv   = b4_s8;
		pq_ld.err  = err_s8 || (b4_s8 == '0);
		pq_ld.t16  = t16_s8;
		pq_ld.tsat = tsat_s8;
	end

	// Stage 9: p and its square term
	pq_t         pq_last;
	logic [32:0] p_c;
	logic [24:0] pm;

	assign pq_last = pq_s[PQ_QW-1];
	assign p_c     = pq_last.sel ? {pq_last.qn, 1'b0} : {1'b0, pq_last.qn};
	assign pm      = p_c[32:8];

	// Output: pressure sum and saturation
	logic [45:0]        x1p;
	logic signed [48:0] pres;
	logic [21:0]        pres_c;
	logic               psat_c;

	always_comb begin
		x1p  = m3_s10[61:16];
		pres = 49'($signed({1'b0, p_s10, 4'b0})) + 49'($signed({1'b0, x1p}))
			+ 49'(x2_s10) + P_OFFSET;
		psat_c = 1'b0;
		if (pres < 49'sd0) begin
			pres_c = '0;
			psat_c = 1'b1;
		end else if (pres > 49'($signed({1'b0, PRES_MAX}))) begin
			pres_c = PRES_MAX;
			psat_c = 1'b1;
		end else begin
			pres_c = pres[21:0];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < TQ_QW; k++) tq_v_s[k] <= 1'b0;
			for (int k = 0; k < PQ_QW; k++) pq_v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			tq_v_s[0] <= v_s1;
			for (int k = 1; k < TQ_QW; k++) tq_v_s[k] <= tq_v_s[k-1];
			v_s3 <= tq_v_s[TQ_QW-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			pq_v_s[0] <= v_s8;
			for (int k = 1; k < PQ_QW; k++) pq_v_s[k] <= pq_v_s[k-1];
			v_s9  <= pq_v_s[PQ_QW-1];
			v_s10 <= v_s9;
			out_valid_q <= v_s10;
		end
	end

	// Datapath: advance every stage together, hold on stall
	always_ff @(posedge clk) begin
		if (adv) begin
			prod1_s1 <= t_diff * $signed({1'b0, ac5});
			up_s1    <= uncomp_pressure;

			tq_s[0] <= tq_step(tq_ld);
			for (int k = 1; k < TQ_QW; k++) tq_s[k] <= tq_step(tq_s[k-1]);

			b6_s3   <= 29'(b5) - 29'(B6_OFFSET);
			up_s3   <= tq_last.up;
			err_s3  <= tq_last.err;
			t16_s3  <= t16_c;
			tsat_s3 <= tsat_c;

			sqp_s4   <= sqp_c;
			ac2b6_s4 <= ac2b6_c;
			ac3b6_s4 <= ac3b6_c;
			up_s4    <= up_s3;
			err_s4   <= err_s3;
			t16_s4   <= t16_s3;
			tsat_s4  <= tsat_s3;

			b2sq_s5  <= b2sq_c;
			b1sq_s5  <= b1sq_c;
			ac2b6_s5 <= ac2b6_s4;
			ac3b6_s5 <= ac3b6_s4;
			up_s5    <= up_s4;
			err_s5   <= err_s4;
			t16_s5   <= t16_s4;
			tsat_s5  <= tsat_s4;

			x3a_s6  <= x3a_c;
			x3b_s6  <= 45'(x3b_sum >>> 2);
			up_s6   <= up_s5;
			err_s6  <= err_s5;
			t16_s6  <= t16_s5;
			tsat_s6 <= tsat_s5;

			b3_s7   <= b3_r[33:2];
			b4p_s7  <= b4_full[31:0];
			up_s7   <= up_s6;
			err_s7  <= err_s6;
			t16_s7  <= t16_s6;
			tsat_s7 <= tsat_s6;

			b7_s8   <= b7_full[31:0];
			b4_s8   <= b4p_s7[31:15];
			err_s8  <= err_s7;
			t16_s8  <= t16_s7;
			tsat_s8 <= tsat_s7;

			pq_s[0] <= pq_step(pq_ld);
			for (int k = 1; k < PQ_QW; k++) pq_s[k] <= pq_step(pq_s[k-1]);

			p_s9    <= p_c;
			sqr_s9  <= pm * pm;
			x2m_s9  <= P_LIN_GAIN * $signed({1'b0, p_c});
			err_s9  <= pq_last.err;
			t16_s9  <= pq_last.t16;
			tsat_s9 <= pq_last.tsat;

			p_s10    <= p_s9;
			m3_s10   <= sqr_s9 * 62'(P_SQ_GAIN);
			x2_s10   <= 32'(x2m_s9 >>> 16);
			err_s10  <= err_s9;
			t16_s10  <= t16_s9;
			tsat_s10 <= tsat_s9;

			if (err_s10) begin
				temperature_tenths  <= '0;
				pressure_sixteenths <= '0;
				status              <= ST_DIV_ZERO;
			end else begin
				temperature_tenths  <= t16_s10;
				pressure_sixteenths <= pres_c;
				status              <= (tsat_s10 || psat_c) ? ST_SATURATED : ST_OK;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/bptc_port_checker.sv
// Port-level checks on the compensation block's output channel and result fields.
// Depends on bptc_pkg; bound to baro_pressure_temp_compensation below.
`default_nettype none

module bptc_port_checker
	import bptc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] temperature_tenths,
	input wire logic [21:0]        pressure_sixteenths,
	input wire logic [1:0]         status
);

	// A waiting result blocks new transfers
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while result stalled");

	// Held result keeps its payload
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable(temperature_tenths) && $stable(pressure_sixteenths) && $stable(status))
		else $error("stalled result changed");

	// Division by zero reports zero values
	a_div_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV_ZERO |-> temperature_tenths == 16'sd0
			&& pressure_sixteenths == 22'd0)
		else $error("nonzero values with division-by-zero status");

	// Saturation always shows a clamp bound
	a_saturation_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SATURATED |-> temperature_tenths == TEMP_MAX
			|| temperature_tenths == TEMP_MIN || pressure_sixteenths == 22'd0
			|| pressure_sixteenths == PRES_MAX)
		else $error("saturated status without a clamped value");

endmodule

bind baro_pressure_temp_compensation bptc_port_checker u_bptc_port_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_ready            (in_ready),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.temperature_tenths  (temperature_tenths),
	.pressure_sixteenths (pressure_sixteenths),
	.status              (status)
);

`default_nettype wire
